// ===== design/fgf_pkg.sv =====
package fgf_pkg;

   localparam int BLOCK_BITS = 48;
   localparam int FGF_QUEUE_DEPTH = 4;

   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_RANGE  = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   localparam logic [1:0] STATUS_FOUND    = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd2;

   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_RANGE  = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   typedef logic [BLOCK_BITS-1:0] block_type;

   typedef struct packed {
      logic [1:0] opcode;
      block_type  request_size;
      block_type  start_hint;
      block_type  range_start;
      block_type  range_length;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      block_type  alloc_start;
      logic       used_hint;
   } rsp_type;

   // begin: a = length, b = hint; range: a = start, b = saturated end;
   // finish: a = volume size
   typedef struct packed {
      logic [1:0] kind;
      logic       bad;
      block_type  a;
      block_type  b;
   } cmd_type;

endpackage

// ===== design/free_gap_finder_top.sv =====
// Free gap finder: streams allocated ranges in ascending start order and picks
// a free run of blocks, preferring the first fit at or above the hint and else
// the first fit anywhere. A begin transaction sets length and hint, range
// transactions describe allocated extents, a finish transaction closes the
// trailing gap up to volume_blocks and returns one response. One request
// transaction is taken per cycle while the queue is not full: the front end
// classifies it and computes the saturated range end, a QUEUE_DEPTH entry
// queue decouples it from the back end, and the back end retires one queued
// command per cycle against its running search state. A finish is queued,
// then registered in the response register; response stalls hold only finish
// commands. volume_blocks may be written only while no search is in flight.
module free_gap_finder_top #(
   parameter int QUEUE_DEPTH = fgf_pkg::FGF_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fgf_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fgf_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  fgf_pkg::block_type csr_data
);
   import fgf_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type pop_cmd;
   logic    not_empty;
   logic    full;

   fgf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   fgf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .pop_cmd   (pop_cmd),
      .not_empty (not_empty),
      .full      (full)
   );

   fgf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (not_empty),
      .cmd       (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/fgf_front.sv =====
module fgf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fgf_pkg::req_type req_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  fgf_pkg::block_type csr_data,
   input  logic             queue_full,
   output logic             push,
   output fgf_pkg::cmd_type push_cmd
);
   import fgf_pkg::*;

   block_type                volume_ff;
   block_type                volume_in;
   logic [BLOCK_BITS:0]      range_sum;
   logic                     accept;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      volume_in = volume_ff;
      if (csr_valid && csr_ready) begin
         volume_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= '0;
      end else begin
         volume_ff <= volume_in;
      end
   end

   assign range_sum = {1'b0, req_data.range_start} + {1'b0, req_data.range_length};

   always_comb begin
      push_cmd = '0;
      push     = 1'b0;
      case (req_data.opcode)
         OP_BEGIN: begin
            push          = accept;
            push_cmd.kind = CMD_BEGIN;
            push_cmd.a    = req_data.request_size;
            push_cmd.b    = (req_data.start_hint >= volume_ff) ? '0 : req_data.start_hint;
            push_cmd.bad  = (req_data.request_size == '0) ||
                            (req_data.request_size > volume_ff);
         end
         OP_RANGE: begin
            push          = accept;
            push_cmd.kind = CMD_RANGE;
            push_cmd.a    = req_data.range_start;
            // end saturates at the top address
            push_cmd.b    = range_sum[BLOCK_BITS] ? '1 : range_sum[BLOCK_BITS-1:0];
         end
         OP_FINISH: begin
            push          = accept;
            push_cmd.kind = CMD_FINISH;
            push_cmd.a    = volume_ff;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/fgf_queue.sv =====
module fgf_queue #(
   parameter int DEPTH = fgf_pkg::FGF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fgf_pkg::cmd_type push_cmd,
   input  logic             pop,
   output fgf_pkg::cmd_type pop_cmd,
   output logic             not_empty,
   output logic             full
);
   import fgf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == FULL_COUNT);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/fgf_back.sv =====
module fgf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  fgf_pkg::cmd_type cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fgf_pkg::rsp_type rsp_data
);
   import fgf_pkg::*;

   block_type req_len_ff, req_len_in;
   block_type hint_pos_ff, hint_pos_in;
   logic      bad_ff, bad_in;
   block_type covered_ff, covered_in;
   block_type hinted_start_ff, hinted_start_in;
   logic      hinted_found_ff, hinted_found_in;
   block_type fallback_start_ff, fallback_start_in;
   logic      fallback_found_ff, fallback_found_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic      is_finish;
   logic      gap_open;
   block_type cand;
   logic      hint_fit;
   logic      fallback_fit;

   assign is_finish = (cmd.kind == CMD_FINISH);
   assign pop       = cmd_valid && (!is_finish || !rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // gap is [covered end, cmd.a)
   assign gap_open     = cmd.a > covered_ff;
   assign cand         = (covered_ff > hint_pos_ff) ? covered_ff : hint_pos_ff;
   assign hint_fit     = gap_open && !hinted_found_ff && (cmd.a > hint_pos_ff) &&
                         ((cmd.a - cand) >= req_len_ff);
   assign fallback_fit = gap_open && !fallback_found_ff &&
                         ((cmd.a - covered_ff) >= req_len_ff);

   always_comb begin
      req_len_in        = req_len_ff;
      hint_pos_in       = hint_pos_ff;
      bad_in            = bad_ff;
      covered_in        = covered_ff;
      hinted_start_in   = hinted_start_ff;
      hinted_found_in   = hinted_found_ff;
      fallback_start_in = fallback_start_ff;
      fallback_found_in = fallback_found_ff;
      rsp_data_in       = rsp_data_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      if (pop) begin
         case (cmd.kind)
            CMD_BEGIN: begin
               req_len_in        = cmd.a;
               hint_pos_in       = cmd.b;
               bad_in            = cmd.bad;
               covered_in        = '0;
               hinted_start_in   = '0;
               hinted_found_in   = 1'b0;
               fallback_start_in = '0;
               fallback_found_in = 1'b0;
            end
            CMD_RANGE, CMD_FINISH: begin
               if (hint_fit) begin
                  hinted_start_in = cand;
                  hinted_found_in = 1'b1;
               end
               if (fallback_fit) begin
                  fallback_start_in = covered_ff;
                  fallback_found_in = 1'b1;
               end
               if (!is_finish && cmd.b > covered_ff) begin
                  covered_in = cmd.b;
               end
               if (is_finish) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  if (bad_ff) begin
                     rsp_data_in.status = STATUS_INVALID;
                  end else if (hinted_found_in) begin
                     rsp_data_in.status      = STATUS_FOUND;
                     rsp_data_in.alloc_start = hinted_start_in;
                     rsp_data_in.used_hint   = 1'b1;
                  end else if (fallback_found_in) begin
                     rsp_data_in.status      = STATUS_FOUND;
                     rsp_data_in.alloc_start = fallback_start_in;
                  end else begin
                     rsp_data_in.status = STATUS_NO_SPACE;
                  end
               end
            end
            default: begin
               rsp_data_in = rsp_data_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_len_ff        <= '0;
         hint_pos_ff       <= '0;
         bad_ff            <= 1'b0;
         covered_ff        <= '0;
         hinted_start_ff   <= '0;
         hinted_found_ff   <= 1'b0;
         fallback_start_ff <= '0;
         fallback_found_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         req_len_ff        <= req_len_in;
         hint_pos_ff       <= hint_pos_in;
         bad_ff            <= bad_in;
         covered_ff        <= covered_in;
         hinted_start_ff   <= hinted_start_in;
         hinted_found_ff   <= hinted_found_in;
         fallback_start_ff <= fallback_start_in;
         fallback_found_ff <= fallback_found_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== design/fgf_checker.sv =====
module fgf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input fgf_pkg::req_type   req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input fgf_pkg::rsp_type   rsp_data,
   input logic               csr_valid,
   input logic               csr_ready,
   input fgf_pkg::block_type csr_data
);
   import fgf_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // only a found result carries a start or the hint flag
   a_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_FOUND |->
         rsp_data.alloc_start == '0 && !rsp_data.used_hint)
      else $error("non-found response carries a start");

   // reset empties the output register and the queue
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // a stalled request transaction holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // register writes are always taken and carry known data
   a_csr_take: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready && !$isunknown(csr_data))
      else $error("register write not taken");

endmodule

bind free_gap_finder_top fgf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);

// ===== dv/free_gap_finder_top_tb.sv =====
module free_gap_finder_top_tb;
   import fgf_pkg::*;

   localparam block_type  BLOCK_MAX = '1;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = FGF_QUEUE_DEPTH + 8;
   localparam int LONG_HOLD = 150;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 95;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_VOLUME} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      item;
      rsp_type      want;
      block_type    volume;
   } stim_row_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   req_type   req_data = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   rsp_type   rsp_data;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   block_type csr_data = '0;

   // search model state
   block_type vol_blocks = '0;
   block_type want_len = '0;
   block_type hint_at = '0;
   bit        req_bad = 1'b0;
   block_type scanned_end = '0;
   block_type hint_pick = '0;
   bit        hint_ok = 1'b0;
   block_type first_pick = '0;
   bit        first_ok = 1'b0;

   rsp_type   expected_rsp[$];
   rsp_type   want_rsp;
   bit        req_idling = 1'b1;
   bit        rsp_idling = 1'b1;
   bit        hold_now = 1'b0;
   int        fail_count = 0;
   int        items_sent = 0;
   int        responses_checked = 0;
   int        volumes_written = 0;
   int        idle_cycles = 0;

   free_gap_finder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic block_type rnd48();
      return block_type'({$urandom, $urandom});
   endfunction

   function automatic block_type rand_upto(block_type m);
      logic [63:0] r;
      r = {$urandom, $urandom};
      return block_type'(r % ({16'd0, m} + 64'd1));
   endfunction

   function automatic int pick_gap();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   // unused fields carry random bits so every input bit toggles
   function automatic req_type mk_item(logic [1:0] op, block_type f1, block_type f2);
      req_type t;
      t.opcode = op;
      t.request_size = rnd48();
      t.start_hint = rnd48();
      t.range_start = rnd48();
      t.range_length = rnd48();
      if (op == OP_BEGIN) begin
         t.request_size = f1;
         t.start_hint = f2;
      end else if (op == OP_RANGE) begin
         t.range_start = f1;
         t.range_length = f2;
      end
      return t;
   endfunction

   // free run [lo, hi): hinted candidate first, then plain first fit
   function automatic void close_gap(block_type lo, block_type hi);
      block_type cand;
      if (hi <= lo) return;
      if (!hint_ok && hi > hint_at) begin
         cand = (lo > hint_at) ? lo : hint_at;
         if (hi - cand >= want_len) begin
            hint_pick = cand;
            hint_ok = 1'b1;
         end
      end
      if (!first_ok && hi - lo >= want_len) begin
         first_pick = lo;
         first_ok = 1'b1;
      end
   endfunction

   function automatic bit predict_search(input req_type t, output rsp_type r);
      logic [BLOCK_BITS:0] sum;
      block_type range_end;
      bit made;
      r = '0;
      made = 1'b0;
      case (t.opcode)
         OP_BEGIN: begin
            want_len = t.request_size;
            hint_at = (t.start_hint >= vol_blocks) ? '0 : t.start_hint;
            req_bad = (t.request_size == '0) || (t.request_size > vol_blocks);
            scanned_end = '0;
            hint_pick = '0;
            hint_ok = 1'b0;
            first_pick = '0;
            first_ok = 1'b0;
         end
         OP_RANGE: begin
            close_gap(scanned_end, t.range_start);
            sum = {1'b0, t.range_start} + {1'b0, t.range_length};
            range_end = sum[BLOCK_BITS] ? BLOCK_MAX : sum[BLOCK_BITS-1:0];
            if (range_end > scanned_end) scanned_end = range_end;
         end
         OP_FINISH: begin
            close_gap(scanned_end, vol_blocks);
            made = 1'b1;
            if (req_bad) begin
               r.status = STATUS_INVALID;
            end else if (hint_ok) begin
               r.status = STATUS_FOUND;
               r.alloc_start = hint_pick;
               r.used_hint = 1'b1;
            end else if (first_ok) begin
               r.status = STATUS_FOUND;
               r.alloc_start = first_pick;
            end else begin
               r.status = STATUS_NO_SPACE;
            end
         end
         default: ;
      endcase
      return made;
   endfunction

   task automatic send_item(input req_type t, input bit typed = 1'b0, input rsp_type want = '0);
      rsp_type got;
      req_data <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (t.opcode != OP_UNUSED) items_sent++;
      if (predict_search(t, got)) expected_rsp.push_back(typed ? want : got);
      if (req_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // an item with no response may still be in the pipe after the last response
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_volume(block_type v);
      wait_idle();
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      vol_blocks = v;
      volumes_written++;
   endtask

   task automatic run_search(block_type vol, bit broken);
      block_type len, hint, cursor, st, ln, span;
      int nr;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: len = rand_upto(vol / 8) + 1;
         5, 6:          len = rand_upto(vol);
         7:             len = vol + block_type'($urandom_range(0, 1));
         8:             len = 1;
         default:       len = rnd48();
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: hint = (vol == '0) ? '0 : rand_upto(vol - 1);
         5:             hint = '0;
         6, 7:          hint = vol + rand_upto(block_type'(16));
         8:             hint = rnd48();
         default:       hint = vol - 1;
      endcase
      if (!broken || $urandom_range(0, 2) != 0) send_item(mk_item(OP_BEGIN, len, hint));
      nr = $urandom_range(0, 6);
      span = vol / block_type'(2 * nr + 2) + 1;
      cursor = '0;
      repeat (nr) begin
         st = cursor + rand_upto(span);
         ln = rand_upto(span);
         if ($urandom_range(0, 19) == 0) ln = rnd48();
         if (broken && $urandom_range(0, 1) == 0) st = rand_upto(vol);
         send_item(mk_item(OP_RANGE, st, ln));
         cursor = (st + ln < st) ? BLOCK_MAX : st + ln;
      end
      send_item(mk_item(OP_FINISH, '0, '0));
      if ($urandom_range(0, 6) == 0) send_item(mk_item(OP_FINISH, '0, '0));
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int n;
      forever begin
         n = 0;
         if (hold_now) begin
            n = LONG_HOLD;
            hold_now = 1'b0;
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            n = pick_gap();
         end
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_checked++;
         if (expected_rsp.size() == 0) begin
            $error("response transaction with nothing expected: %p", rsp_data);
            fail_count++;
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_data.status !== want_rsp.status) begin
               $error("status expected %0d got %0d", want_rsp.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.alloc_start !== want_rsp.alloc_start) begin
               $error("alloc_start expected %0d got %0d", want_rsp.alloc_start,
                      rsp_data.alloc_start);
               fail_count++;
            end
            if (rsp_data.used_hint !== want_rsp.used_hint) begin
               $error("used_hint expected %0d got %0d", want_rsp.used_hint,
                      rsp_data.used_hint);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no transaction for %0d cycles, %0d responses outstanding",
                  idle_cycles, expected_rsp.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_type rows[$];
      block_type phase_volume[8];
      int target;
      int pick;

      rows.push_back('{ROW_TYPED, mk_item(OP_FINISH, '0, '0),
                       '{STATUS_NO_SPACE, '0, 1'b0}, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_BEGIN, 5, 0), '0, '0});
      rows.push_back('{ROW_TYPED, mk_item(OP_FINISH, '0, '0),
                       '{STATUS_INVALID, '0, 1'b0}, '0});
      rows.push_back('{ROW_VOLUME, '0, '0, 48'd1000});
      rows.push_back('{ROW_PREDICT, mk_item(OP_BEGIN, 0, 0), '0, '0});
      rows.push_back('{ROW_TYPED, mk_item(OP_FINISH, '0, '0),
                       '{STATUS_INVALID, '0, 1'b0}, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_BEGIN, 1001, 3), '0, '0});
      rows.push_back('{ROW_TYPED, mk_item(OP_FINISH, '0, '0),
                       '{STATUS_INVALID, '0, 1'b0}, '0});
      // a gap too small, a fitting gap below the hint, an empty gap, an overlapping range
      rows.push_back('{ROW_PREDICT, mk_item(OP_BEGIN, 10, 500), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_RANGE, 0, 100), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_RANGE, 105, 50), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_RANGE, 300, 300), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_RANGE, 600, 10), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_RANGE, 550, 5), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_UNUSED, rnd48(), rnd48()), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_FINISH, '0, '0), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_FINISH, '0, '0), '0, '0});
      // hint too close to the end, first fit must win
      rows.push_back('{ROW_PREDICT, mk_item(OP_BEGIN, 50, 980), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_RANGE, 0, 100), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_RANGE, 200, 10), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_FINISH, '0, '0), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_BEGIN, 1000, 2000), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_FINISH, '0, '0), '0, '0});
      rows.push_back('{ROW_VOLUME, '0, '0, BLOCK_MAX});
      // saturating range end at full width
      rows.push_back('{ROW_PREDICT, mk_item(OP_BEGIN, BLOCK_MAX, BLOCK_MAX), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_RANGE, BLOCK_MAX, BLOCK_MAX), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_FINISH, '0, '0), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_BEGIN, 1, 5), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_RANGE, 0, BLOCK_MAX), '0, '0});
      rows.push_back('{ROW_PREDICT, mk_item(OP_FINISH, '0, '0), '0, '0});

      phase_volume[0] = 48'd64;
      phase_volume[1] = 48'd1;
      phase_volume[2] = 48'd1000;
      phase_volume[3] = BLOCK_MAX;
      phase_volume[4] = rnd48();
      phase_volume[5] = '0;
      phase_volume[6] = 48'd5000;
      phase_volume[7] = rand_upto(48'd1048576);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_VOLUME) write_volume(rows[i].volume);
         else send_item(rows[i].item, rows[i].kind == ROW_TYPED, rows[i].want);
      end

      foreach (phase_volume[p]) begin
         write_volume(phase_volume[p]);
         if (p == 2) begin
            // long receiver hold-off while finishes keep coming: queue fills
            req_idling = 1'b0;
            hold_now = 1'b1;
            send_item(mk_item(OP_BEGIN, 3, 0));
            repeat (24) send_item(mk_item(OP_FINISH, '0, '0));
            wait_idle();
            req_idling = 1'b1;
         end
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            if ($urandom_range(0, 15) == 0) begin
               req_idling = $urandom_range(0, 3) != 0;
               rsp_idling = $urandom_range(0, 3) != 0;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)
               send_item(mk_item(2'($urandom_range(0, 3)), rnd48(), rnd48()));
            else
               run_search(phase_volume[p], pick < 4);
         end
      end

      wait_idle();
      $display("sent %0d search transactions over %0d volume settings (empty to full width)",
               items_sent, volumes_written);
      $display("checked %0d responses, %0d mismatches", responses_checked, fail_count);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/fgf_pkg.sv
design/fgf_front.sv
design/fgf_queue.sv
design/fgf_back.sv
design/free_gap_finder_top.sv
design/fgf_checker.sv
dv/free_gap_finder_top_tb.sv
